/* hw/rtl/multichannel_biquad_notch_filter_unit_defines.svh */
// Assertion macros for the multichannel biquad notch filter unit.
// Included by the top level; no other dependencies.
`ifndef MULTICHANNEL_BIQUAD_NOTCH_FILTER_UNIT_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_NOTCH_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define MBNF_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mbnf assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MBNF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mbnf assertion failed");
`else
`define MBNF_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define MBNF_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/mbnf_pkg.sv */
// Shared types, constants and arithmetic helpers for the biquad filter unit.
// Used by the controller, the datapath and the top level.
package mbnf_pkg;

    localparam int MAX_CHANNELS   = 64;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 30;
    localparam int COEF_W         = 32;
    localparam int HIST_BITS      = 48;
    localparam int CHAN_W         = 6;
    localparam int CHAN_CNT_W     = 7;
    localparam int CFG_IDX_W      = 3;
    localparam int HIST_ADDR_W    = $clog2(MAX_CHANNELS);

    localparam int PROD_W = COEF_W + SAMPLE_WIDTH;
    localparam int WIDE_W = ((PROD_W > HIST_BITS) ? PROD_W : HIST_BITS) + 2;
    localparam int SUM_W  = HIST_BITS + 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]       coef_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [HIST_BITS-1:0]    hist_t;
    typedef logic signed [SUM_W-1:0]        sum_t;
    typedef logic signed [WIDE_W-1:0]       wide_t;
    typedef logic [CHAN_W-1:0]              chan_t;
    typedef logic [CHAN_CNT_W-1:0]          chan_cnt_t;
    typedef logic [COEF_W-1:0]              cfg_data_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 3'd0,
        CFG_CHANNELS = 3'd1,
        CFG_B0       = 3'd2,
        CFG_B1       = 3'd3,
        CFG_B2       = 3'd4,
        CFG_A1       = 3'd5,
        CFG_A2       = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MUL_B0X,
        MUL_B1X,
        MUL_A1Y,
        MUL_B2X,
        MUL_A2Y
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     rd_en;
        mul_sel_t mul_sel;
        logic     acc_y;
        logic     t1_init;
        logic     t1_sub;
        logic     t2_init;
        logic     t2_sub;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic bypass;
        logic out_free;
    } ctrl_stat_t;

    localparam coef_t COEF_ONE =
        {{(COEF_W-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};
    localparam wide_t ROUND_HALF =
        {{(WIDE_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam wide_t HIST_MAX =
        {{(WIDE_W-HIST_BITS+1){1'b0}}, {(HIST_BITS-1){1'b1}}};
    localparam wide_t HIST_MIN =
        {{(WIDE_W-HIST_BITS+1){1'b1}}, {(HIST_BITS-1){1'b0}}};
    localparam wide_t SMP_MAX =
        {{(WIDE_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam wide_t SMP_MIN =
        {{(WIDE_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    function automatic hist_t sat_hist(input wide_t v);
        hist_t r;
        if (v > HIST_MAX) begin
            r = HIST_MAX[HIST_BITS-1:0];
        end else if (v < HIST_MIN) begin
            r = HIST_MIN[HIST_BITS-1:0];
        end else begin
            r = v[HIST_BITS-1:0];
        end
        return r;
    endfunction

    function automatic sample_t sat_sample(input wide_t v);
        sample_t r;
        if (v > SMP_MAX) begin
            r = SMP_MAX[SAMPLE_WIDTH-1:0];
        end else if (v < SMP_MIN) begin
            r = SMP_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/mbnf_ctrl.sv */
// Sequencing state machine for the biquad filter unit.
// Depends on mbnf_pkg for the command and status structs.
module mbnf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mbnf_pkg::ctrl_stat_t stat,
    output mbnf_pkg::ctrl_cmd_t  cmd
);
    import mbnf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_Y,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_WB
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_B0X;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = stat.bypass ? S_WB : S_RD;
                end
            end
            S_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.mul_sel = MUL_B0X;
                state_next  = S_Y;
            end
            S_Y: begin
                cmd.acc_y   = 1'b1;
                cmd.mul_sel = MUL_B1X;
                state_next  = S_P1;
            end
            S_P1: begin
                cmd.t1_init = 1'b1;
                cmd.mul_sel = MUL_A1Y;
                state_next  = S_P2;
            end
            S_P2: begin
                cmd.t1_sub  = 1'b1;
                cmd.mul_sel = MUL_B2X;
                state_next  = S_P3;
            end
            S_P3: begin
                cmd.t2_init = 1'b1;
                cmd.mul_sel = MUL_A2Y;
                state_next  = S_P4;
            end
            S_P4: begin
                cmd.t2_sub = 1'b1;
                state_next = S_WB;
            end
            S_WB: begin
                // Hold here until the output register can take the word.
                cmd.out_load = stat.out_free;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/mbnf_dp.sv */
// Datapath of the biquad filter unit: configuration registers, history
// memory, shared multiplier, accumulators and output register. Uses mbnf_pkg.
module mbnf_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  mbnf_pkg::cfg_idx_t   cfg_idx,
    input  mbnf_pkg::cfg_data_t  cfg_wdata,
    input  mbnf_pkg::chan_t      s_channel,
    input  mbnf_pkg::sample_t    s_sample_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mbnf_pkg::sample_t    m_sample_out,
    output logic                 m_filtered,
    input  mbnf_pkg::ctrl_cmd_t  cmd,
    output mbnf_pkg::ctrl_stat_t stat
);
    import mbnf_pkg::*;

    logic      enable_reg;
    chan_cnt_t chans_reg;
    coef_t     b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    logic [MAX_CHANNELS-1:0]  hvalid_reg;
    logic [2*HIST_BITS-1:0]   hist_mem [MAX_CHANNELS];
    logic [2*HIST_BITS-1:0]   rd_reg;
    logic                     rd_valid_reg;

    chan_t   ch_reg;
    sample_t x_reg;
    logic    byp_reg;
    prod_t   prod_reg;
    sample_t y_reg;
    sum_t    t1_reg, t2_reg;

    logic    m_valid_reg, m_valid_next;
    sample_t m_sample_reg;
    logic    m_filtered_reg;

    logic    bypass_now;
    coef_t   mul_a;
    sample_t mul_b;
    hist_t   h1, h2, prod_sat;
    wide_t   acc;
    logic    hist_we;

    assign bypass_now = !enable_reg
                     || ({1'b0, s_channel} >= chans_reg)
                     || ({1'b0, s_channel} >= chan_cnt_t'(MAX_CHANNELS));

    assign stat.bypass   = bypass_now;
    assign stat.out_free = !m_valid_reg || m_ready;

    // A history entry that has not been written since the last clear reads as zero.
    assign h1 = rd_valid_reg ? rd_reg[2*HIST_BITS-1:HIST_BITS] : '0;
    assign h2 = rd_valid_reg ? rd_reg[HIST_BITS-1:0] : '0;

    assign prod_sat = sat_hist(wide_t'(prod_reg));
    assign acc      = wide_t'(prod_reg) + wide_t'(h1) + ROUND_HALF;
    assign hist_we  = cmd.out_load && !byp_reg;

    always_comb begin
        case (cmd.mul_sel)
            MUL_B0X: begin mul_a = b0_reg; mul_b = x_reg; end
            MUL_B1X: begin mul_a = b1_reg; mul_b = x_reg; end
            MUL_A1Y: begin mul_a = a1_reg; mul_b = y_reg; end
            MUL_B2X: begin mul_a = b2_reg; mul_b = x_reg; end
            MUL_A2Y: begin mul_a = a2_reg; mul_b = y_reg; end
            default: begin mul_a = b0_reg; mul_b = x_reg; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            chans_reg  <= '0;
            b0_reg     <= COEF_ONE;
            b1_reg     <= '0;
            b2_reg     <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_ENABLE:   enable_reg <= cfg_wdata[0];
                CFG_CHANNELS: chans_reg  <= cfg_wdata[CHAN_CNT_W-1:0];
                CFG_B0:       b0_reg     <= cfg_wdata;
                CFG_B1:       b1_reg     <= cfg_wdata;
                CFG_B2:       b2_reg     <= cfg_wdata;
                CFG_A1:       a1_reg     <= cfg_wdata;
                CFG_A2:       a2_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Writing the channel count drops every history back to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hvalid_reg <= '0;
        end else if (cfg_we && (cfg_idx == CFG_CHANNELS)) begin
            hvalid_reg <= '0;
        end else if (hist_we) begin
            hvalid_reg[ch_reg[HIST_ADDR_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[ch_reg[HIST_ADDR_W-1:0]] <= {sat_hist(wide_t'(t1_reg)),
                                                  sat_hist(wide_t'(t2_reg))};
        end
        if (cmd.rd_en) begin
            rd_reg       <= hist_mem[ch_reg[HIST_ADDR_W-1:0]];
            rd_valid_reg <= hvalid_reg[ch_reg[HIST_ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_t'(mul_a) * prod_t'(mul_b);
        if (cmd.load_in) begin
            ch_reg  <= s_channel;
            x_reg   <= s_sample_in;
            byp_reg <= bypass_now;
        end
        if (cmd.acc_y) begin
            y_reg <= sat_sample(acc >>> COEF_FRAC_BITS);
        end
        if (cmd.t1_init) begin
            t1_reg <= sum_t'(prod_sat) + sum_t'(h2);
        end else if (cmd.t1_sub) begin
            t1_reg <= t1_reg - sum_t'(prod_sat);
        end
        if (cmd.t2_init) begin
            t2_reg <= sum_t'(prod_sat);
        end else if (cmd.t2_sub) begin
            t2_reg <= t2_reg - sum_t'(prod_sat);
        end
        if (cmd.out_load) begin
            m_sample_reg   <= byp_reg ? x_reg : y_reg;
            m_filtered_reg <= !byp_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_filtered   = m_filtered_reg;

endmodule

/* hw/rtl/multichannel_biquad_notch_filter_unit.sv */
// Multichannel biquad filter unit, top level: controller plus datapath.
// Depends on mbnf_pkg, mbnf_ctrl, mbnf_dp and the assertion macro header.
//
// Second-order IIR filter in transposed direct form II with one pair of
// 48-bit histories per channel and five signed Q2.30 coefficients. A filtered
// word passes from acceptance to the output register through an accept step,
// a history read, then the single shared 32x16 multiplier forms b0*x, b1*x,
// a1*y, b2*x and a2*y one per cycle, and a last step writes the histories
// back and loads the result. A bypassed word goes from acceptance straight
// to the write-back step. The next word is accepted once the previous result
// sits in the output register, so a result waiting for m_ready does not hold
// up the following computation. Histories read as zero after reset and after
// any write of the channel count; there is no clearing pass.
`include "multichannel_biquad_notch_filter_unit_defines.svh"

module multichannel_biquad_notch_filter_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  mbnf_pkg::cfg_idx_t  cfg_idx,
    input  mbnf_pkg::cfg_data_t cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  mbnf_pkg::chan_t     s_channel,
    input  mbnf_pkg::sample_t   s_sample_in,
    output logic                m_valid,
    input  logic                m_ready,
    output mbnf_pkg::sample_t   m_sample_out,
    output logic                m_filtered
);
    import mbnf_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    mbnf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mbnf_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .s_channel    (s_channel),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_filtered   (m_filtered),
        .cmd          (cmd),
        .stat         (stat)
    );

    // Only one word is in flight, so an accepted word closes the input.
    `MBNF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A fresh result is loaded only as the controller returns to idle.
    `MBNF_ASSERT_IMPL(a_result_frees_input, aclk, aresetn, $rose(m_valid), s_ready)
    // Loading a result always leaves a valid word in the output register.
    `MBNF_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, cmd.out_load, m_valid)

endmodule
